FILE: rtl/core/drm_pkg.sv
// ----------------------------------------------------------------------------
// Dirty rectangle merger package
// Shared types, register indexes, request codes and reset values.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int MaxRectsDef = 5;

  localparam logic [19:0] ThresholdRst = 20'd8000;
  localparam logic [14:0] ScreenWRst   = 15'd640;
  localparam logic [14:0] ScreenHRst   = 15'd480;
  localparam logic        RefreshRst   = 1'b0;
  localparam logic        ShadowRst    = 1'b1;
  localparam logic        SortRst      = 1'b0;
  localparam logic [2:0]  AlignRst     = 3'd0;
  localparam logic [2:0]  DepthRst     = 3'd3;

  localparam logic [2:0] CfgThreshold = 3'd0;
  localparam logic [2:0] CfgScreenW   = 3'd1;
  localparam logic [2:0] CfgScreenH   = 3'd2;
  localparam logic [2:0] CfgRefresh   = 3'd3;
  localparam logic [2:0] CfgShadow    = 3'd4;
  localparam logic [2:0] CfgSort      = 3'd5;
  localparam logic [2:0] CfgAlign     = 3'd6;
  localparam logic [2:0] CfgDepth     = 3'd7;

  localparam logic [1:0] FuncAccrue = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncFlush  = 2'd2;

  typedef struct packed {
    logic signed [15:0] t;
    logic signed [15:0] l;
    logic signed [15:0] b;
    logic signed [15:0] r;
  } rect_t;

  typedef struct packed {
    logic [14:0] screen_w;
    logic [14:0] screen_h;
    logic [2:0]  align;
    logic [2:0]  depth;
  } clip_cfg_t;

endpackage

FILE: rtl/core/drm_clip.sv
// ----------------------------------------------------------------------------
// Dirty rectangle clipper
// Clips a stored rectangle to the screen and aligns its horizontal edges.
// ----------------------------------------------------------------------------
module drm_clip (
  input  drm_pkg::rect_t     rect_i,
  input  drm_pkg::clip_cfg_t cfg_i,
  output drm_pkg::rect_t     rect_o
);

  logic signed [15:0] sw_s;
  logic signed [15:0] sh_s;
  logic signed [15:0] right0;
  logic [9:0]         g_m1;
  logic [9:0]         lmask;
  logic signed [25:0] r_ext;
  logic signed [25:0] r_sh;
  logic signed [25:0] g_ext;
  logic signed [25:0] r_ceil;
  logic signed [25:0] r_al;
  logic [3:0]         gsh;

  always_comb begin
    sw_s   = $signed({1'b0, cfg_i.screen_w});
    sh_s   = $signed({1'b0, cfg_i.screen_h});
    right0 = (rect_i.r > sw_s) ? sw_s : rect_i.r;
    gsh    = {1'b0, cfg_i.align} + 4'd2;
    g_m1   = 10'((11'd1 << gsh) - 11'd1);
    lmask  = g_m1 >> cfg_i.depth;
    r_ext  = {{10{right0[15]}}, right0};
    r_sh   = r_ext <<< cfg_i.depth;
    g_ext  = $signed({16'b0, g_m1});
    r_ceil = (r_sh + g_ext) & ~g_ext;
    r_al   = r_ceil >>> cfg_i.depth;

    rect_o.t = (rect_i.t < 0) ? 16'sd0 : rect_i.t;
    rect_o.b = (rect_i.b > sh_s) ? sh_s : rect_i.b;
    if (rect_i.l < 0) begin
      rect_o.l = 16'sd0;
    end else if (cfg_i.align != 3'd0) begin
      rect_o.l = rect_i.l & ~$signed({6'b0, lmask});
    end else begin
      rect_o.l = rect_i.l;
    end
    if (cfg_i.align == 3'd0) begin
      rect_o.r = right0;
    end else if (r_al > 26'sd32767) begin
      rect_o.r = 16'sd32767;
    end else begin
      rect_o.r = r_al[15:0];
    end
  end

endmodule

FILE: rtl/core/dirty_rectangle_merger_unit.sv
// ----------------------------------------------------------------------------
// Dirty rectangle merger unit
// Keeps a short list of dirty rectangles in a small memory; merges, queries
// and flushes them with a sequencer around one multiplier.
// Accrue runs up to N merge passes (N = MAX_RECTS), each scanning the entries
// with two multiplies per entry read; query scans up to N entries; flush does
// one scan of the n entries per result. One item is taken at a time, and each
// result is registered and shown as a one-cycle strobe.
// Reset empties the list and loads register defaults; entries are not cleared.
// ----------------------------------------------------------------------------
module dirty_rectangle_merger_unit #(
  parameter int MAX_RECTS = drm_pkg::MaxRectsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] in_top_i,
  input  logic signed [15:0] in_left_i,
  input  logic signed [15:0] in_bottom_i,
  input  logic signed [15:0] in_right_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  output logic               out_valid_o,
  output logic signed [15:0] out_top_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_bottom_o,
  output logic signed [15:0] out_right_o,
  output logic               last_o,
  output logic               subsumed_o
);

  localparam int IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CntW = $clog2(MAX_RECTS + 1);

  typedef enum logic [16:0] {
    StIdle  = 17'h00001,
    StFirst = 17'h00002,
    StArea  = 17'h00004,
    StSRd   = 17'h00008,
    StSEv   = 17'h00010,
    StSM1   = 17'h00020,
    StSM2   = 17'h00040,
    StSCmp  = 17'h00080,
    StDRd   = 17'h00100,
    StDMrg  = 17'h00200,
    StMRd   = 17'h00400,
    StMWr   = 17'h00800,
    StQRd   = 17'h01000,
    StQEv   = 17'h02000,
    StFRd   = 17'h04000,
    StFEv   = 17'h08000,
    StFEmit = 17'h10000
  } state_e;

  state_e state_q, state_d;
  drm_pkg::rect_t a_q, a_d, fbest_q, fbest_d, out_q, out_d;
  logic [CntW-1:0] n_q, n_d, n_m1;
  logic [IdxW-1:0] i_q, i_d, best_q, best_d, k_q, k_d;
  logic have_q, have_d;
  logic [32:0] best_add_q, best_add_d;
  logic [31:0] a_area_q, a_area_d, prod_u_q, prod_u_d, prod_e_q, prod_e_d;
  logic [15:0] uw_q, uw_d, uh_q, uh_d, ew_q, ew_d, eh_q, eh_d;
  logic [MAX_RECTS-1:0] emitted_q, emitted_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d, out_sub_q, out_sub_d;

  logic [19:0] thr_q, thr_d;
  logic [14:0] sw_q, sw_d, sh_q, sh_d;
  logic refresh_q, refresh_d, shadow_q, shadow_d, sort_q, sort_d;
  logic [2:0] align_q, align_d, depth_q, depth_d;

  drm_pkg::rect_t mem [MAX_RECTS];
  drm_pkg::rect_t rd_data_q, wr_data, e, u, clipped;
  logic rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;

  logic [15:0] mul_x, mul_y;
  logic [31:0] mul_p;
  logic signed [33:0] diff;
  logic [32:0] ad;
  drm_pkg::clip_cfg_t clip_cfg;
  logic ovl, contain, grows, merge, cand, is_last;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign clip_cfg = '{screen_w: sw_q, screen_h: sh_q, align: align_q, depth: depth_q};

  drm_clip u_clip (
    .rect_i (rd_data_q),
    .cfg_i  (clip_cfg),
    .rect_o (clipped)
  );

  assign mul_p = mul_x * mul_y;
  assign e     = rd_data_q;
  assign n_m1  = n_q - CntW'(1);

  always_comb begin
    u.t = (a_q.t < e.t) ? a_q.t : e.t;
    u.l = (a_q.l < e.l) ? a_q.l : e.l;
    u.b = (a_q.b > e.b) ? a_q.b : e.b;
    u.r = (a_q.r > e.r) ? a_q.r : e.r;
    ovl = (a_q.t < e.b) && (e.t < a_q.b) && (a_q.l < e.r) && (e.l < a_q.r);
    contain = (e.t <= a_q.t) && (e.l <= a_q.l) && (e.b >= a_q.b) && (e.r >= a_q.r);
    grows = (a_q.t < e.t) || (a_q.l < e.l) || (a_q.b > e.b) || (a_q.r > e.r);
    diff = $signed({2'b0, prod_u_q}) - $signed({2'b0, a_area_q})
         - $signed({2'b0, prod_e_q});
    ad = diff[33] ? 33'd0 : diff[32:0];
    merge = (best_add_q <= {13'b0, thr_q}) || (n_q == CntW'(MAX_RECTS));
    cand = !emitted_q[i_q] && (!have_q || (sort_q && (clipped.t < fbest_q.t)));
    is_last = (CntW'(k_q) == n_m1);
  end

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    fbest_d    = fbest_q;
    out_d      = out_q;
    n_d        = n_q;
    i_d        = i_q;
    best_d     = best_q;
    k_d        = k_q;
    have_d     = have_q;
    best_add_d = best_add_q;
    a_area_d   = a_area_q;
    prod_u_d   = prod_u_q;
    prod_e_d   = prod_e_q;
    uw_d       = uw_q;
    uh_d       = uh_q;
    ew_d       = ew_q;
    eh_d       = eh_q;
    emitted_d  = emitted_q;
    out_valid_d = 1'b0;
    out_last_d = out_last_q;
    out_sub_d  = out_sub_q;
    rd_en      = 1'b0;
    rd_addr    = i_q;
    wr_en      = 1'b0;
    wr_addr    = best_q;
    wr_data    = a_q;
    mul_x      = uw_q;
    mul_y      = uh_q;

    thr_d     = thr_q;
    sw_d      = sw_q;
    sh_d      = sh_q;
    refresh_d = refresh_q;
    shadow_d  = shadow_q;
    sort_d    = sort_q;
    align_d   = align_q;
    depth_d   = depth_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        drm_pkg::CfgThreshold: thr_d     = cfg_data_i;
        drm_pkg::CfgScreenW:   sw_d      = cfg_data_i[14:0];
        drm_pkg::CfgScreenH:   sh_d      = cfg_data_i[14:0];
        drm_pkg::CfgRefresh:   refresh_d = cfg_data_i[0];
        drm_pkg::CfgShadow:    shadow_d  = cfg_data_i[0];
        drm_pkg::CfgSort:      sort_d    = cfg_data_i[0];
        drm_pkg::CfgAlign:     align_d   = cfg_data_i[2:0];
        drm_pkg::CfgDepth:     depth_d   = cfg_data_i[2:0];
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (start) begin
          a_d = '{t: in_top_i, l: in_left_i, b: in_bottom_i, r: in_right_i};
          case (func_i)
            drm_pkg::FuncAccrue: begin
              if (!(in_bottom_i <= in_top_i || in_right_i <= in_left_i ||
                    refresh_q || !shadow_q)) begin
                state_d = (n_q == '0) ? StFirst : StArea;
              end
            end
            drm_pkg::FuncQuery: begin
              if (n_q == '0) begin
                out_d       = '0;
                out_valid_d = 1'b1;
                out_last_d  = 1'b1;
                out_sub_d   = 1'b0;
              end else begin
                i_d     = n_m1[IdxW-1:0];
                state_d = StQRd;
              end
            end
            drm_pkg::FuncFlush: begin
              if (n_q != '0) begin
                i_d       = '0;
                k_d       = '0;
                have_d    = 1'b0;
                emitted_d = '0;
                state_d   = StFRd;
              end
            end
            default: ;
          endcase
        end
      end
      StFirst: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        n_d     = CntW'(1);
        state_d = StIdle;
      end
      StArea: begin
        mul_x    = 16'(a_q.r - a_q.l);
        mul_y    = 16'(a_q.b - a_q.t);
        a_area_d = mul_p;
        i_d      = n_m1[IdxW-1:0];
        have_d   = 1'b0;
        state_d  = StSRd;
      end
      StSRd: begin
        rd_en   = 1'b1;
        state_d = StSEv;
      end
      StSEv: begin
        if (ovl) begin
          best_d     = i_q;
          best_add_d = '0;
          state_d    = StDRd;
        end else begin
          uw_d    = 16'(u.r - u.l);
          uh_d    = 16'(u.b - u.t);
          ew_d    = 16'(e.r - e.l);
          eh_d    = 16'(e.b - e.t);
          state_d = StSM1;
        end
      end
      StSM1: begin
        prod_u_d = mul_p;
        state_d  = StSM2;
      end
      StSM2: begin
        mul_x    = ew_q;
        mul_y    = eh_q;
        prod_e_d = mul_p;
        state_d  = StSCmp;
      end
      StSCmp: begin
        if (!have_q || ad < best_add_q) begin
          have_d     = 1'b1;
          best_add_d = ad;
          best_d     = i_q;
        end
        if (i_q == '0) begin
          state_d = StDRd;
        end else begin
          i_d     = i_q - IdxW'(1);
          state_d = StSRd;
        end
      end
      StDRd: begin
        if (merge) begin
          rd_en   = 1'b1;
          rd_addr = best_q;
          state_d = StDMrg;
        end else begin
          wr_en   = 1'b1;
          wr_addr = n_q[IdxW-1:0];
          n_d     = n_q + CntW'(1);
          state_d = StIdle;
        end
      end
      StDMrg: begin
        if (n_q == CntW'(1)) begin
          wr_en   = 1'b1;
          wr_data = u;
          state_d = StIdle;
        end else if (grows) begin
          a_d     = u;
          n_d     = n_m1;
          state_d = StMRd;
        end else begin
          state_d = StIdle;
        end
      end
      StMRd: begin
        rd_en   = 1'b1;
        rd_addr = n_q[IdxW-1:0];
        state_d = StMWr;
      end
      StMWr: begin
        wr_en   = 1'b1;
        wr_data = rd_data_q;
        state_d = StArea;
      end
      StQRd: begin
        rd_en   = 1'b1;
        state_d = StQEv;
      end
      StQEv: begin
        if (contain || i_q == '0) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_sub_d   = contain;
          state_d     = StIdle;
        end else begin
          i_d     = i_q - IdxW'(1);
          state_d = StQRd;
        end
      end
      StFRd: begin
        rd_en   = 1'b1;
        state_d = StFEv;
      end
      StFEv: begin
        if (cand) begin
          fbest_d = clipped;
          best_d  = i_q;
          have_d  = 1'b1;
        end
        if (CntW'(i_q) == n_m1) begin
          state_d = StFEmit;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = StFRd;
        end
      end
      StFEmit: begin
        out_d             = fbest_q;
        out_valid_d       = 1'b1;
        out_last_d        = is_last;
        out_sub_d         = 1'b0;
        emitted_d[best_q] = 1'b1;
        if (is_last) begin
          n_d     = '0;
          state_d = StIdle;
        end else begin
          k_d     = k_q + IdxW'(1);
          i_d     = '0;
          have_d  = 1'b0;
          state_d = StFRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= drm_pkg::ThresholdRst;
      sw_q        <= drm_pkg::ScreenWRst;
      sh_q        <= drm_pkg::ScreenHRst;
      refresh_q   <= drm_pkg::RefreshRst;
      shadow_q    <= drm_pkg::ShadowRst;
      sort_q      <= drm_pkg::SortRst;
      align_q     <= drm_pkg::AlignRst;
      depth_q     <= drm_pkg::DepthRst;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      sw_q        <= sw_d;
      sh_q        <= sh_d;
      refresh_q   <= refresh_d;
      shadow_q    <= shadow_d;
      sort_q      <= sort_d;
      align_q     <= align_d;
      depth_q     <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    fbest_q    <= fbest_d;
    out_q      <= out_d;
    i_q        <= i_d;
    best_q     <= best_d;
    k_q        <= k_d;
    have_q     <= have_d;
    best_add_q <= best_add_d;
    a_area_q   <= a_area_d;
    prod_u_q   <= prod_u_d;
    prod_e_q   <= prod_e_d;
    uw_q       <= uw_d;
    uh_q       <= uh_d;
    ew_q       <= ew_d;
    eh_q       <= eh_d;
    emitted_q  <= emitted_d;
    out_last_q <= out_last_d;
    out_sub_q  <= out_sub_d;
  end

  assign busy         = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign out_top_o    = out_q.t;
  assign out_left_o   = out_q.l;
  assign out_bottom_o = out_q.b;
  assign out_right_o  = out_q.r;
  assign last_o       = out_last_q;
  assign subsumed_o   = out_sub_q;

endmodule

FILE: tb/sv/tb_dirty_rectangle_merger_unit.sv
// ----------------------------------------------------------------------------
// Dirty rectangle merger unit testbench
// Drives accrue, query and flush items through the command handshake under
// several register settings, predicts every result from a local model of the
// rectangle list and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb_dirty_rectangle_merger_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRects = drm_pkg::MaxRectsDef;
  localparam int SettleCycles = 200;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct {
    drm_pkg::rect_t box;
    logic           last;
    logic           subsumed;
  } rect_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func_i = drm_pkg::FuncAccrue;
  logic signed [15:0] in_top_i = '0;
  logic signed [15:0] in_left_i = '0;
  logic signed [15:0] in_bottom_i = '0;
  logic signed [15:0] in_right_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = drm_pkg::CfgThreshold;
  logic [19:0]        cfg_data_i = '0;
  logic               out_valid_o;
  logic signed [15:0] out_top_o, out_left_o, out_bottom_o, out_right_o;
  logic               last_o, subsumed_o;

  dirty_rectangle_merger_unit u_top (.*);

  // Local copy of the list and registers.
  drm_pkg::rect_t dirty_list [NumRects];
  int             dirty_len;
  logic [19:0]    thr_q;
  logic [14:0]    scr_w_q, scr_h_q;
  logic           refresh_q, shadow_q, sort_q;
  logic [2:0]     align_q, depth_q;

  rect_result_t pending_rects [$];
  int           errors = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  logic         start_hi = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint box_area(drm_pkg::rect_t a);
    return (longint'(a.r) - longint'(a.l)) * (longint'(a.b) - longint'(a.t));
  endfunction

  function automatic longint grow_cost(drm_pkg::rect_t a, longint a_area,
                                       drm_pkg::rect_t e);
    longint t, l, b, r, d;
    t = (a.t < e.t) ? a.t : e.t;
    l = (a.l < e.l) ? a.l : e.l;
    b = (a.b > e.b) ? a.b : e.b;
    r = (a.r > e.r) ? a.r : e.r;
    d = (r - l) * (b - t) - (a_area + box_area(e));
    return (d < 0) ? 0 : d;
  endfunction

  function automatic void merge_rect(drm_pkg::rect_t a);
    int n, best;
    bit done, grows;
    longint a_area, best_add, ad;
    n = dirty_len;
    done = 0;
    if (n == 0) begin
      dirty_list[0] = a;
      dirty_len = 1;
      return;
    end
    while (!done) begin
      a_area = box_area(a);
      best_add = 64'h7fff_ffff_ffff_ffff;
      best = 0;
      for (int i = n - 1; i >= 0; i--) begin
        if (a.t < dirty_list[i].b && dirty_list[i].t < a.b &&
            a.l < dirty_list[i].r && dirty_list[i].l < a.r) begin
          best_add = 0;
          best = i;
          break;
        end
        ad = grow_cost(a, a_area, dirty_list[i]);
        if (ad < best_add) begin
          best_add = ad;
          best = i;
        end
      end
      if (best_add <= longint'(thr_q) || n == NumRects) begin
        if (n == 1) begin
          if (a.t < dirty_list[best].t) dirty_list[best].t = a.t;
          if (a.l < dirty_list[best].l) dirty_list[best].l = a.l;
          if (a.b > dirty_list[best].b) dirty_list[best].b = a.b;
          if (a.r > dirty_list[best].r) dirty_list[best].r = a.r;
          done = 1;
        end else begin
          grows = 0;
          if (dirty_list[best].t <= a.t) a.t = dirty_list[best].t; else grows = 1;
          if (dirty_list[best].l <= a.l) a.l = dirty_list[best].l; else grows = 1;
          if (dirty_list[best].b >= a.b) a.b = dirty_list[best].b; else grows = 1;
          if (dirty_list[best].r >= a.r) a.r = dirty_list[best].r; else grows = 1;
          if (grows) begin
            n--;
            dirty_list[best] = dirty_list[n];
          end else begin
            done = 1;
          end
        end
      end else begin
        dirty_list[n] = a;
        n++;
        done = 1;
      end
    end
    dirty_len = n;
  endfunction

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic drm_pkg::rect_t clip_rect(drm_pkg::rect_t e);
    longint left, right, g, mask, pix;
    left = e.l;
    right = e.r;
    if (e.t < 0) e.t = 0;
    if (int'(e.b) > int'(scr_h_q)) e.b = 16'(scr_h_q);
    if (right > longint'(scr_w_q)) right = scr_w_q;
    if (align_q != 0) begin
      g = longint'(8) << (align_q - 1);
      mask = (g - 1) >> depth_q;
      pix = longint'(1) << depth_q;
      if (left >= 0) left = left & ~mask;
      right = floor_div(-floor_div(-(right * pix), g) * g, pix);
      if (right > 32767) right = 32767;
    end
    if (left < 0) left = 0;
    e.l = 16'(left);
    e.r = 16'(right);
    return e;
  endfunction

  function automatic void predict_item(logic [1:0] f, drm_pkg::rect_t a);
    rect_result_t res;
    drm_pkg::rect_t tmp;
    if (f == drm_pkg::FuncAccrue) begin
      if (a.b > a.t && a.r > a.l && !refresh_q && shadow_q) merge_rect(a);
    end else if (f == drm_pkg::FuncQuery) begin
      res.box = '0;
      res.last = 1'b1;
      res.subsumed = 1'b0;
      for (int i = dirty_len - 1; i >= 0; i--) begin
        if (dirty_list[i].t <= a.t && dirty_list[i].l <= a.l &&
            dirty_list[i].b >= a.b && dirty_list[i].r >= a.r) begin
          res.subsumed = 1'b1;
          break;
        end
      end
      pending_rects.push_back(res);
    end else if (f == drm_pkg::FuncFlush && dirty_len != 0) begin
      for (int i = 0; i < dirty_len; i++) dirty_list[i] = clip_rect(dirty_list[i]);
      if (sort_q) begin
        for (int i = dirty_len - 1; i > 0; i--)
          for (int j = 0; j < i; j++)
            if (dirty_list[j].t > dirty_list[j + 1].t) begin
              tmp = dirty_list[j];
              dirty_list[j] = dirty_list[j + 1];
              dirty_list[j + 1] = tmp;
            end
      end
      for (int i = 0; i < dirty_len; i++) begin
        res.box = dirty_list[i];
        res.last = (i == dirty_len - 1);
        res.subsumed = 1'b0;
        pending_rects.push_back(res);
      end
      dirty_len = 0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      results_seen++;
      if (pending_rects.size() == 0) begin
        $error("unexpected result: top %0d left %0d bottom %0d right %0d",
               out_top_o, out_left_o, out_bottom_o, out_right_o);
        errors++;
      end else begin
        rect_result_t x;
        x = pending_rects.pop_front();
        if (out_top_o !== x.box.t) begin
          $error("out_top expected %0d actual %0d", x.box.t, out_top_o); errors++;
        end
        if (out_left_o !== x.box.l) begin
          $error("out_left expected %0d actual %0d", x.box.l, out_left_o); errors++;
        end
        if (out_bottom_o !== x.box.b) begin
          $error("out_bottom expected %0d actual %0d", x.box.b, out_bottom_o); errors++;
        end
        if (out_right_o !== x.box.r) begin
          $error("out_right expected %0d actual %0d", x.box.r, out_right_o); errors++;
        end
        if (last_o !== x.last) begin
          $error("last expected %0d actual %0d", x.last, last_o); errors++;
        end
        if (subsumed_o !== x.subsumed) begin
          $error("subsumed expected %0d actual %0d", x.subsumed, subsumed_o); errors++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] f, int t, int l, int b, int r, int gap);
    drm_pkg::rect_t a;
    a = '{t: 16'(t), l: 16'(l), b: 16'(b), r: 16'(r)};
    if (gap > 0 && start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    start <= 1'b1;
    start_hi = 1'b1;
    func_i <= f;
    in_top_i <= a.t;
    in_left_i <= a.l;
    in_bottom_i <= a.b;
    in_right_i <= a.r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_item(f, a);
    items_sent++;
  endtask

  task automatic drain_results();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      drm_pkg::CfgThreshold: thr_q = val;
      drm_pkg::CfgScreenW:   scr_w_q = val[14:0];
      drm_pkg::CfgScreenH:   scr_h_q = val[14:0];
      drm_pkg::CfgRefresh:   refresh_q = val[0];
      drm_pkg::CfgShadow:    shadow_q = val[0];
      drm_pkg::CfgSort:      sort_q = val[0];
      drm_pkg::CfgAlign:     align_q = val[2:0];
      default:               depth_q = val[2:0];
    endcase
    @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_random(int count);
    int p, t, l, b, r;
    logic [1:0] f;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 60) f = drm_pkg::FuncAccrue;
      else if (p < 80) f = drm_pkg::FuncQuery;
      else if (p < 95) f = drm_pkg::FuncFlush;
      else f = FuncUnused;
      if ($urandom_range(0, 9) == 0) begin
        t = $urandom_range(0, 65535);
        l = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        r = $urandom_range(0, 65535);
      end else begin
        t = int'($urandom_range(0, 560)) - 40;
        l = int'($urandom_range(0, 720)) - 40;
        b = t + int'($urandom_range(0, 150)) - ($urandom_range(0, 15) == 0 ? 30 : 0);
        r = l + int'($urandom_range(0, 150)) - ($urandom_range(0, 15) == 0 ? 30 : 0);
      end
      send_item(f, t, l, b, r, (k % 40 < 8) ? 0 : pick_gap());
    end
  endtask

  task automatic test_directed();
    send_item(drm_pkg::FuncQuery, 0, 0, 1, 1, 0);
    send_item(drm_pkg::FuncFlush, 0, 0, 0, 0, 0);
    send_item(drm_pkg::FuncAccrue, 10, 10, 10, 20, 0);
    send_item(drm_pkg::FuncAccrue, 10, 20, 20, 20, 1);
    send_item(FuncUnused, -1, -1, -1, -1, 0);
    send_item(drm_pkg::FuncAccrue, -32768, -32768, 32767, 32767, 0);
    send_item(drm_pkg::FuncQuery, -32768, -32768, 32767, 32767, 0);
    send_item(drm_pkg::FuncQuery, -32768, -32768, 32767, 32767, 2);
    send_item(drm_pkg::FuncFlush, 0, 0, 0, 0, 0);
    drain_results();
    write_reg(drm_pkg::CfgThreshold, 20'd0);
    send_item(drm_pkg::FuncAccrue, 0, 0, 10, 10, 0);
    send_item(drm_pkg::FuncAccrue, 5, 5, 15, 15, 0);
    send_item(drm_pkg::FuncAccrue, 100, 100, 110, 110, 0);
    send_item(drm_pkg::FuncAccrue, 200, 200, 210, 210, 0);
    send_item(drm_pkg::FuncAccrue, 300, 300, 310, 310, 0);
    send_item(drm_pkg::FuncAccrue, 400, 400, 410, 410, 0);
    send_item(drm_pkg::FuncAccrue, 450, 10, 460, 20, 0);
    send_item(drm_pkg::FuncQuery, 101, 101, 109, 109, 0);
    send_item(drm_pkg::FuncQuery, 0, 0, 500, 500, 0);
    send_item(drm_pkg::FuncFlush, 0, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_register_phases();
    write_reg(drm_pkg::CfgThreshold, 20'hfffff);
    write_reg(drm_pkg::CfgScreenW, 20'd32767);
    write_reg(drm_pkg::CfgScreenH, 20'd32767);
    write_reg(drm_pkg::CfgSort, 20'd1);
    write_reg(drm_pkg::CfgAlign, 20'd4);
    write_reg(drm_pkg::CfgDepth, 20'd0);
    send_random(50);
    drain_results();
    write_reg(drm_pkg::CfgThreshold, 20'd0);
    write_reg(drm_pkg::CfgScreenW, 20'd0);
    write_reg(drm_pkg::CfgScreenH, 20'd0);
    write_reg(drm_pkg::CfgAlign, 20'd7);
    write_reg(drm_pkg::CfgDepth, 20'd7);
    send_random(50);
    drain_results();
    write_reg(drm_pkg::CfgRefresh, 20'd1);
    send_random(15);
    drain_results();
    write_reg(drm_pkg::CfgRefresh, 20'd0);
    write_reg(drm_pkg::CfgShadow, 20'd0);
    send_random(15);
    drain_results();
    write_reg(drm_pkg::CfgShadow, 20'd1);
    write_reg(drm_pkg::CfgThreshold, 20'd200);
    write_reg(drm_pkg::CfgScreenW, 20'd640);
    write_reg(drm_pkg::CfgScreenH, 20'd480);
    write_reg(drm_pkg::CfgSort, 20'd0);
    for (int k = 1; k <= 5; k++) begin
      write_reg(drm_pkg::CfgAlign, 20'(k));
      write_reg(drm_pkg::CfgDepth, 20'($urandom_range(0, 5)));
      write_reg(drm_pkg::CfgSort, 20'(k % 2));
      send_random(40);
      drain_results();
    end
  endtask

  task automatic test_random_defaults();
    write_reg(drm_pkg::CfgThreshold, 20'd8000);
    write_reg(drm_pkg::CfgAlign, 20'd0);
    write_reg(drm_pkg::CfgDepth, 20'd3);
    write_reg(drm_pkg::CfgSort, 20'd0);
    send_random(60);
    drain_results();
  endtask

  initial begin
    dirty_len = 0;
    thr_q = drm_pkg::ThresholdRst;
    scr_w_q = drm_pkg::ScreenWRst;
    scr_h_q = drm_pkg::ScreenHRst;
    refresh_q = drm_pkg::RefreshRst;
    shadow_q = drm_pkg::ShadowRst;
    sort_q = drm_pkg::SortRst;
    align_q = drm_pkg::AlignRst;
    depth_q = drm_pkg::DepthRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    test_directed();
    test_register_phases();
    test_random_defaults();
    drain_results();
    $display("Sent %0d items and checked %0d results across clipping, alignment,",
             items_sent, results_seen);
    $display("sorting, threshold and accrue-disable register settings.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
